FILE: src/rtc_cal_pkg.sv
// Package for the calendar clock: item codes, calendar constants and the
// month length, leap year and weekday helpers.
// No dependencies.
package rtc_cal_pkg;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  localparam logic [15:0] TPS_RESET   = 16'd1000;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;
  localparam logic [5:0]  MIN_PER_HR  = 6'd60;
  localparam logic [4:0]  HR_PER_DAY  = 5'd24;
  localparam logic [3:0]  MONTHS      = 4'd12;
  localparam logic [11:0] YEAR_MAX    = 12'd4095;

  localparam logic [5:0]  SEC_RESET   = 6'd0;
  localparam logic [5:0]  MIN_RESET   = 6'd8;
  localparam logic [4:0]  HR_RESET    = 5'd10;
  localparam logic [4:0]  DAY_RESET   = 5'd2;
  localparam logic [3:0]  MON_RESET   = 4'd3;
  localparam logic [11:0] YEAR_RESET  = 12'd2022;
  localparam logic [2:0]  WDAY_RESET  = 3'd3;

  // x / 25 for x < 2048 by reciprocal multiply (1311 / 2^15)
  function automatic logic [6:0] div25(logic [10:0] x);
    logic [26:0] p;
    p = {16'd0, x} * 27'd1311;
    return p[21:15];
  endfunction

  function automatic logic is_leap(logic [11:0] y);
    logic [6:0]  q;
    logic [10:0] q25;
    logic        div4;
    logic        div100;
    logic        div400;
    q      = div25({1'b0, y[11:2]});
    q25    = {4'd0, q} * 11'd25;
    div4   = (y[1:0] == 2'd0);
    div100 = div4 && (q25 == {1'b0, y[11:2]});
    div400 = div100 && (q[1:0] == 2'd0);
    return div4 && (!div100 || div400);
  endfunction

  // Out of range months read as December
  function automatic logic [4:0] month_len(logic [3:0] m, logic [11:0] y);
    logic [4:0] len;
    case (m)
      4'd2:                    len = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Larsson's formula, year offset by 400 so January of year 0 stays positive.
  // m must be 1..12.
  function automatic logic [2:0] weekday_of(logic [11:0] y, logic [3:0] m, logic [4:0] d);
    logic [12:0] yy;
    logic [3:0]  mm;
    logic [3:0]  t;
    logic [10:0] y4;
    logic [6:0]  c;
    logic [12:0] s;
    logic [28:0] p;
    logic [12:0] q;
    logic [12:0] r;
    yy = {1'b0, y} + 13'd400;
    mm = m;
    if (m <= 4'd2) begin
      mm = m + 4'd12;
      yy = yy - 13'd1;
    end
    // 3 * (mm + 1) / 5
    case (mm)
      4'd3:    t = 4'd2;
      4'd4:    t = 4'd3;
      4'd5:    t = 4'd3;
      4'd6:    t = 4'd4;
      4'd7:    t = 4'd4;
      4'd8:    t = 4'd5;
      4'd9:    t = 4'd6;
      4'd10:   t = 4'd6;
      4'd11:   t = 4'd7;
      4'd12:   t = 4'd7;
      4'd13:   t = 4'd8;
      4'd14:   t = 4'd9;
      default: t = 4'd0;
    endcase
    y4 = yy[12:2];
    c  = div25(y4);
    s  = {8'd0, d} + {8'd0, mm, 1'b0} + {9'd0, t} + yy + {2'd0, y4}
       - {6'd0, c} + {8'd0, c[6:2]} + 13'd1;
    // s mod 7 by reciprocal multiply (9363 / 2^16)
    p = {16'd0, s} * 29'd9363;
    q = p[28:16];
    r = s - q * 13'd7;
    return r[2:0];
  endfunction

endpackage

FILE: src/calendar_clock_with_tick_prescaler_core.sv
// Calendar clock top level: input register, calendar update logic, result
// register and the clock state. Depends on rtc_cal_pkg.
//
// Calendar clock with a millisecond tick prescaler. Each input transfer is
// either a tick (tuser = 0) or a set command (tuser = 1). A tick adds one to
// the free-running 32-bit millisecond count and to the prescaler; when the
// prescaler reaches ticks_per_second (0 behaves as 1) it clears, second_strobe
// is raised and the second carries through minutes, hours, days (Gregorian
// month lengths, leap Februaries), months and years; the weekday (0 = Sunday)
// steps at each day rollover and the year holds at 4095. A set command loads
// the date and time with out of range values clamped (day clamped to the month
// length) and works out the weekday; it leaves the millisecond count and the
// prescaler alone. Every input transfer gives exactly one output transfer with
// the time after the update. Throughput is one transfer per clock while m_tready is
// high: a transfer lands in the input register, and once the result register can
// move on, clock state and result register update together, so the next item already
// sees the new state. The weekday calculation on a set command is the longest
// path. ticks_per_second is written through cfg_wr_en / cfg_wr_data and should
// only change while no transfer is in flight. Reset is synchronous, active high,
// and gives 10:08:00 on Wednesday 2 March 2022 with ticks_per_second = 1000.
module calendar_clock_with_tick_prescaler_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [11:0] set_year, [15:12] set_month, [20:16] set_day, [25:21] set_hour,
  // [31:26] set_minute, [37:32] set_second, [39:38] zero
  input  logic [39:0] s_tdata,
  // [0] opcode
  input  logic        s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [11:0] year_out, [15:12] month_out, [20:16] day_out, [25:21] hour_out,
  // [31:26] minute_out, [37:32] second_out, [40:38] weekday_out,
  // [72:41] millis_out, [79:73] zero
  output logic [79:0] m_tdata,
  // [0] second_strobe
  output logic        m_tuser,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // configuration register
  logic [15:0] ticks_per_second;

  // clock state
  logic [15:0] prescale_count;
  logic [31:0] millis_count;
  logic [5:0]  sec_reg;
  logic [5:0]  min_reg;
  logic [4:0]  hour_reg;
  logic [4:0]  day_reg;
  logic [3:0]  month_reg;
  logic [11:0] year_reg;
  logic [2:0]  weekday_reg;

  logic [15:0] prescale_count_next;
  logic [31:0] millis_count_next;
  logic [5:0]  sec_reg_next;
  logic [5:0]  min_reg_next;
  logic [4:0]  hour_reg_next;
  logic [4:0]  day_reg_next;
  logic [3:0]  month_reg_next;
  logic [11:0] year_reg_next;
  logic [2:0]  weekday_reg_next;
  logic        strobe_next;

  // input register
  logic                in_valid;
  rtc_cal_pkg::op_t    in_op;
  logic [37:0]         in_data;

  // result register
  logic        out_valid;
  logic [79:0] out_data;
  logic        out_strobe;

  logic advance;
  logic fire;

  // The result register moves on when it is empty or being taken; the input
  // register can then always hand its item over, so it takes a new one too.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_strobe;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= rtc_cal_pkg::TPS_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= rtc_cal_pkg::op_t'(s_tuser);
      in_data <= s_tdata[37:0];
    end
  end

  // Calendar update for the item in the input register
  logic [11:0] f_year;
  logic [3:0]  f_month;
  logic [4:0]  f_day;
  logic [4:0]  f_hour;
  logic [5:0]  f_min;
  logic [5:0]  f_sec;
  logic [3:0]  c_month;
  logic [4:0]  c_len;
  logic [4:0]  c_day;
  logic [16:0] pre_inc;
  logic [5:0]  sec_inc;
  logic [5:0]  min_inc;
  logic [4:0]  hour_inc;
  logic [5:0]  day_inc;

  assign f_year  = in_data[11:0];
  assign f_month = in_data[15:12];
  assign f_day   = in_data[20:16];
  assign f_hour  = in_data[25:21];
  assign f_min   = in_data[31:26];
  assign f_sec   = in_data[37:32];

  // set path: clamp the month first, the day then follows its length
  always_comb begin
    if (f_month == 4'd0) begin
      c_month = 4'd1;
    end else if (f_month > rtc_cal_pkg::MONTHS) begin
      c_month = rtc_cal_pkg::MONTHS;
    end else begin
      c_month = f_month;
    end
    c_len = rtc_cal_pkg::month_len(c_month, f_year);
    if (f_day == 5'd0) begin
      c_day = 5'd1;
    end else if (f_day > c_len) begin
      c_day = c_len;
    end else begin
      c_day = f_day;
    end
  end

  assign pre_inc  = {1'b0, prescale_count} + 17'd1;
  assign sec_inc  = sec_reg + 6'd1;
  assign min_inc  = min_reg + 6'd1;
  assign hour_inc = hour_reg + 5'd1;
  assign day_inc  = {1'b0, day_reg} + 6'd1;

  always_comb begin
    prescale_count_next = prescale_count;
    millis_count_next   = millis_count;
    sec_reg_next        = sec_reg;
    min_reg_next        = min_reg;
    hour_reg_next       = hour_reg;
    day_reg_next        = day_reg;
    month_reg_next      = month_reg;
    year_reg_next       = year_reg;
    weekday_reg_next    = weekday_reg;
    strobe_next         = 1'b0;
    case (in_op)
      rtc_cal_pkg::OP_TICK: begin
        millis_count_next = millis_count + 32'd1;
        if (pre_inc >= {1'b0, ticks_per_second}) begin
          prescale_count_next = '0;
          strobe_next         = 1'b1;
          // carry chain, each stage only when the one below wraps
          if (sec_inc < rtc_cal_pkg::SEC_PER_MIN) begin
            sec_reg_next = sec_inc;
          end else begin
            sec_reg_next = '0;
            if (min_inc < rtc_cal_pkg::MIN_PER_HR) begin
              min_reg_next = min_inc;
            end else begin
              min_reg_next = '0;
              if (hour_inc < rtc_cal_pkg::HR_PER_DAY) begin
                hour_reg_next = hour_inc;
              end else begin
                hour_reg_next    = '0;
                weekday_reg_next = (weekday_reg >= 3'd6) ? 3'd0 : weekday_reg + 3'd1;
                if (day_inc <= {1'b0, rtc_cal_pkg::month_len(month_reg, year_reg)}) begin
                  day_reg_next = day_inc[4:0];
                end else begin
                  day_reg_next = 5'd1;
                  if (month_reg < rtc_cal_pkg::MONTHS) begin
                    month_reg_next = month_reg + 4'd1;
                  end else begin
                    month_reg_next = 4'd1;
                    if (year_reg != rtc_cal_pkg::YEAR_MAX) begin
                      year_reg_next = year_reg + 12'd1;
                    end
                  end
                end
              end
            end
          end
        end else begin
          prescale_count_next = pre_inc[15:0];
        end
      end
      rtc_cal_pkg::OP_SET: begin
        year_reg_next    = f_year;
        month_reg_next   = c_month;
        day_reg_next     = c_day;
        hour_reg_next    = (f_hour >= rtc_cal_pkg::HR_PER_DAY) ? 5'd23 : f_hour;
        min_reg_next     = (f_min >= rtc_cal_pkg::MIN_PER_HR) ? 6'd59 : f_min;
        sec_reg_next     = (f_sec >= rtc_cal_pkg::SEC_PER_MIN) ? 6'd59 : f_sec;
        weekday_reg_next = rtc_cal_pkg::weekday_of(f_year, c_month, c_day);
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  // state and result register move on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      millis_count   <= '0;
      sec_reg        <= rtc_cal_pkg::SEC_RESET;
      min_reg        <= rtc_cal_pkg::MIN_RESET;
      hour_reg       <= rtc_cal_pkg::HR_RESET;
      day_reg        <= rtc_cal_pkg::DAY_RESET;
      month_reg      <= rtc_cal_pkg::MON_RESET;
      year_reg       <= rtc_cal_pkg::YEAR_RESET;
      weekday_reg    <= rtc_cal_pkg::WDAY_RESET;
    end else if (fire) begin
      prescale_count <= prescale_count_next;
      millis_count   <= millis_count_next;
      sec_reg        <= sec_reg_next;
      min_reg        <= min_reg_next;
      hour_reg       <= hour_reg_next;
      day_reg        <= day_reg_next;
      month_reg      <= month_reg_next;
      year_reg       <= year_reg_next;
      weekday_reg    <= weekday_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data   <= {7'd0, millis_count_next, weekday_reg_next, sec_reg_next, min_reg_next,
                     hour_reg_next, day_reg_next, month_reg_next, year_reg_next};
      out_strobe <= strobe_next;
    end
  end

  // A result carrying the second strobe leaves the prescaler cleared until
  // the next item is processed.
  a_strobe_clears_prescaler: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (prescale_count == 16'd0))
    else $error("prescaler not cleared after second strobe");

  // An item held in the input register is not dropped while the output stalls.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input register lost an item during stall");

  // The calendar state stays in range.
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> ((sec_reg < rtc_cal_pkg::SEC_PER_MIN) && (min_reg < rtc_cal_pkg::MIN_PER_HR)
      && (hour_reg < rtc_cal_pkg::HR_PER_DAY) && (weekday_reg <= 3'd6)
      && (month_reg != 4'd0) && (month_reg <= rtc_cal_pkg::MONTHS) && (day_reg != 5'd0)))
    else $error("calendar state out of range");

endmodule
